// ===== rtl/m3inv_pkg.sv =====
// Shared constants for the 3x3 matrix inverse pipeline.
// Used by the top level and by its port checker; depends on nothing else.
package m3inv_pkg;

   // Number formats of the entries.
   localparam int DATA_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int SHIFT     = 2 * FRAC_BITS;

   // Matrix size and derived datapath widths.
   localparam int NUM    = 9;
   localparam int MIN_W  = 31;
   localparam int PROD_W = 2 * DATA_W;
   localparam int COF_W  = PROD_W + 1;
   localparam int MAG_W  = PROD_W;
   localparam int LO_W   = DATA_W;
   localparam int HI_W   = COF_W - LO_W;
   localparam int PART_W = DATA_W + HI_W;
   localparam int DET_W  = DATA_W + COF_W + 2;
   localparam int ADET_W = DET_W - 1;
   localparam int R_W    = ADET_W + 2;
   localparam int N_W    = R_W + DATA_W;

   // Port widths.
   localparam int IN_W   = NUM * DATA_W;
   localparam int OUT_W  = (NUM + 1) * DATA_W;
   localparam int USER_W = 2;

   // Register stages: seven ahead of the divider, two divider set-up stages,
   // one stage per quotient bit, one output stage.
   localparam int NST   = DATA_W + 10;
   localparam int CNT_W = $clog2(NST + 1);

   // Bit positions in rsp_tuser.
   localparam int USER_CLAMPED   = 0;
   localparam int USER_SATURATED = 1;

endpackage

// ===== rtl/matrix3x3_inverse.sv =====
// Top level of the 3x3 matrix inverse: adjugate over determinant, Q16.16.
// Depends on m3inv_pkg for all widths and stage counts.
//
//  channel | ports                         | content
//  --------+-------------------------------+--------------------------------------
//  req     | req_tvalid/tready/tdata[287:0] | a_00 .. a_22, 32 bits each, row-major
//  rsp     | rsp_tvalid/tready/tdata[319:0] | inv_00 .. inv_22, determinant
//          | rsp_tuser[1:0]                 | det_clamped, saturated
//  csr     | csr_we, csr_wdata[30:0]        | min_det
//
//  One matrix is taken per cycle unless the output stalls and the pipe is full.
//  Most of the pipeline depth is the quotient pipeline, one stage per quotient bit (32).
//  Reset clears every stage valid bit and sets min_det to 1.
//  A stage holds only while the stage after it holds, so bubbles are squeezed out
//  and the input keeps taking transfers while the output waits, until the pipe is full.
module matrix3x3_inverse (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [m3inv_pkg::IN_W-1:0]    req_tdata,   // a_00, a_01, ... a_22 from bit 0 up
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [m3inv_pkg::OUT_W-1:0]   rsp_tdata,   // inv_00 .. inv_22, determinant from bit 0
   output logic [m3inv_pkg::USER_W-1:0]  rsp_tuser,   // det_clamped, saturated from bit 0
   input  logic                          csr_we,
   input  logic [m3inv_pkg::MIN_W-1:0]   csr_wdata
);

   localparam int DW  = m3inv_pkg::DATA_W;
   localparam int NST = m3inv_pkg::NST;
   localparam int NUM = m3inv_pkg::NUM;
   localparam int AW  = m3inv_pkg::ADET_W;
   localparam int RW  = m3inv_pkg::R_W;
   localparam int DIV0 = 7;
   localparam logic [DW-1:0] HALF     = {1'b1, {(DW-1){1'b0}}};
   localparam logic [AW:0]   RND_HALF = (AW+1)'(1) << (m3inv_pkg::SHIFT - 1);
   localparam logic [AW:0]   HALF_D   = (AW+1)'(1) << (DW - 1);

   typedef logic signed [DW-1:0]                   ent_type;
   typedef logic signed [m3inv_pkg::PROD_W-1:0]    prod_type;
   typedef logic signed [m3inv_pkg::COF_W-1:0]     cof_type;
   typedef logic        [m3inv_pkg::MAG_W-1:0]     mag_type;
   typedef logic signed [m3inv_pkg::PART_W-1:0]    part_type;
   typedef logic signed [m3inv_pkg::DET_W-1:0]     det_type;

   typedef struct packed {
      logic [NUM-1:0][RW-1:0] rem;
      logic [NUM-1:0][DW-1:0] low;
      logic [NUM-1:0][DW-1:0] quo;
      logic [NUM-1:0]         neg;
      logic [NUM-1:0]         ovf;
      logic [RW-1:0]          dvs;
      logic [DW-1:0]          det_out;
      logic                   det_sat;
      logic                   clamped;
   } div_type;

   // Configuration register.
   logic [m3inv_pkg::MIN_W-1:0] min_det_ff;
   logic [m3inv_pkg::MIN_W-1:0] min_eff;
   logic [AW-1:0]               lim;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_det_ff <= m3inv_pkg::MIN_W'(1);
      end else if (csr_we) begin
         min_det_ff <= csr_wdata;
      end
   end

   // A zero limit acts as one so the divisor never vanishes.
   assign min_eff = (min_det_ff == '0) ? m3inv_pkg::MIN_W'(1) : min_det_ff;
   assign lim     = AW'(min_eff) << m3inv_pkg::SHIFT;

   // Stage valid bits and the hold chain: a stage loads when empty or when
   // the stage after it moves.
   logic [NST-1:0] v_ff;
   logic [NST:0]   en;

   always_comb begin
      en[NST] = rsp_tready;
      for (int k = NST - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= req_tvalid;
         for (int k = 1; k < NST; k++) begin
            if (en[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = v_ff[NST-1];

   // Stage 0: the eighteen 2x2 minor products.
   ent_type  a_in [3][3];
   prod_type pa_in [3][3], pb_in [3][3];
   prod_type pa_ff [3][3], pb_ff [3][3];
   ent_type  a0_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            a_in[i][j] = req_tdata[(i*3+j)*DW +: DW];
         end
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            pa_in[i][j] = a_in[(i+1)%3][(j+1)%3] * a_in[(i+2)%3][(j+2)%3];
            pb_in[i][j] = a_in[(i+1)%3][(j+2)%3] * a_in[(i+2)%3][(j+1)%3];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         for (int j = 0; j < 3; j++) a0_ff[j] <= a_in[0][j];
      end
   end

   // Stage 1: signed cofactors.
   cof_type cof_in [3][3];
   cof_type cof_ff [3][3];
   ent_type a1_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            cof_in[i][j] = pa_ff[i][j] - pb_ff[i][j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         cof_ff <= cof_in;
         a1_ff  <= a0_ff;
      end
   end

   // Stage 2: cofactor magnitudes and the determinant partial products,
   // each first-row cofactor split into a low and a high half.
   mag_type  mag2_in [3][3];
   logic     cneg2_in [3][3];
   part_type ph_in [3], pl_in [3];
   mag_type  mag2_ff [3][3];
   logic     cneg2_ff [3][3];
   part_type ph_ff [3], pl_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            cneg2_in[i][j] = cof_ff[i][j][m3inv_pkg::COF_W-1];
            mag2_in[i][j]  = cneg2_in[i][j] ? m3inv_pkg::MAG_W'(-cof_ff[i][j])
                                            : m3inv_pkg::MAG_W'(cof_ff[i][j]);
         end
      end
      for (int j = 0; j < 3; j++) begin
         ph_in[j] = a1_ff[j] * $signed(cof_ff[0][j][m3inv_pkg::COF_W-1:m3inv_pkg::LO_W]);
         pl_in[j] = a1_ff[j] * $signed({1'b0, cof_ff[0][j][m3inv_pkg::LO_W-1:0]});
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         mag2_ff  <= mag2_in;
         cneg2_ff <= cneg2_in;
         ph_ff    <= ph_in;
         pl_ff    <= pl_in;
      end
   end

   // Stage 3: the three determinant terms.
   det_type term_in [3];
   det_type term_ff [3];
   mag_type mag3_ff [3][3];
   logic    cneg3_ff [3][3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         term_in[j] = (m3inv_pkg::DET_W'(ph_ff[j]) <<< m3inv_pkg::LO_W)
                    + m3inv_pkg::DET_W'(pl_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         term_ff  <= term_in;
         mag3_ff  <= mag2_ff;
         cneg3_ff <= cneg2_ff;
      end
   end

   // Stage 4: exact determinant.
   det_type det_in;
   det_type det_ff;
   mag_type mag4_ff [3][3];
   logic    cneg4_ff [3][3];

   assign det_in = term_ff[0] + term_ff[1] + term_ff[2];

   always_ff @(posedge clock) begin
      if (en[4]) begin
         det_ff   <= det_in;
         mag4_ff  <= mag3_ff;
         cneg4_ff <= cneg3_ff;
      end
   end

   // Stage 5: determinant magnitude and sign.
   logic [AW-1:0] adet_in;
   logic [AW-1:0] adet_ff;
   logic          dneg5_ff;
   mag_type       mag5_ff [3][3];
   logic          cneg5_ff [3][3];

   assign adet_in = det_ff[m3inv_pkg::DET_W-1] ? AW'(-det_ff) : AW'(det_ff);

   always_ff @(posedge clock) begin
      if (en[5]) begin
         adet_ff  <= adet_in;
         dneg5_ff <= det_ff[m3inv_pkg::DET_W-1];
         mag5_ff  <= mag4_ff;
         cneg5_ff <= cneg4_ff;
      end
   end

   // Stage 6: clamp test, divisor magnitude and the rounded determinant output.
   logic          clamp_in;
   logic [AW-1:0] aused_in;
   logic [AW:0]   drnd, dmag;
   logic          dsat_in;
   logic [DW-1:0] dout_in;
   logic          clamp6_ff, dsat6_ff, dneg6_ff;
   logic [AW-1:0] aused6_ff;
   logic [DW-1:0] dout6_ff;
   mag_type       mag6_ff [3][3];
   logic          cneg6_ff [3][3];

   always_comb begin
      clamp_in = adet_ff < lim;
      aused_in = clamp_in ? lim : adet_ff;
      drnd     = {1'b0, adet_ff} + RND_HALF;
      dmag     = drnd >> m3inv_pkg::SHIFT;
      dsat_in  = dneg5_ff ? (dmag > HALF_D) : (dmag >= HALF_D);
      if (dsat_in) begin
         dout_in = dneg5_ff ? HALF : ~HALF;
      end else begin
         dout_in = dneg5_ff ? -dmag[DW-1:0] : dmag[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         clamp6_ff <= clamp_in;
         aused6_ff <= aused_in;
         dsat6_ff  <= dsat_in;
         dout6_ff  <= dout_in;
         dneg6_ff  <= dneg5_ff;
         mag6_ff   <= mag5_ff;
         cneg6_ff  <= cneg5_ff;
      end
   end

   // Divider: set-up, range check, then one quotient bit per stage.
   // The dividend is 2|cof|*2^SHIFT + |d|, the divisor 2|d|, where |d| is |det| raised
   // to the min_det limit when below it, which rounds the quotient to nearest with ties away from zero.
   div_type div_in [DW+2];
   div_type div_ff [DW+2];

   always_comb begin
      logic [m3inv_pkg::N_W-1:0] num;
      div_in[0] = '0;
      div_in[0].dvs     = RW'({aused6_ff, 1'b0});
      div_in[0].det_out = dout6_ff;
      div_in[0].det_sat = dsat6_ff;
      div_in[0].clamped = clamp6_ff;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            num = (m3inv_pkg::N_W'(mag6_ff[j][i]) << (m3inv_pkg::SHIFT + 1))
                + m3inv_pkg::N_W'(aused6_ff);
            div_in[0].rem[i*3+j] = num[m3inv_pkg::N_W-1:DW];
            div_in[0].low[i*3+j] = num[DW-1:0];
            div_in[0].neg[i*3+j] = cneg6_ff[j][i] ^ dneg6_ff;
         end
      end
   end

   // A quotient that needs more than DW bits saturates.
   always_comb begin
      div_in[1] = div_ff[0];
      for (int e = 0; e < NUM; e++) begin
         div_in[1].ovf[e] = div_ff[0].rem[e] >= div_ff[0].dvs;
         if (div_in[1].ovf[e]) div_in[1].rem[e] = '0;
      end
   end

   for (genvar m = 2; m < DW + 2; m++) begin : g_step
      always_comb begin
         logic [RW:0] rs;
         logic [RW:0] dx;
         div_in[m] = div_ff[m-1];
         dx = {1'b0, div_ff[m-1].dvs};
         for (int e = 0; e < NUM; e++) begin
            rs = {div_ff[m-1].rem[e], div_ff[m-1].low[e][DW-1]};
            div_in[m].low[e] = {div_ff[m-1].low[e][DW-2:0], 1'b0};
            if (rs >= dx) begin
               div_in[m].rem[e] = RW'(rs - dx);
               div_in[m].quo[e] = {div_ff[m-1].quo[e][DW-2:0], 1'b1};
            end else begin
               div_in[m].rem[e] = RW'(rs);
               div_in[m].quo[e] = {div_ff[m-1].quo[e][DW-2:0], 1'b0};
            end
         end
      end
   end

   for (genvar m = 0; m < DW + 2; m++) begin : g_div
      always_ff @(posedge clock) begin
         if (en[DIV0+m]) div_ff[m] <= div_in[m];
      end
   end

   // Output stage: sign, saturation and packing.
   logic [m3inv_pkg::OUT_W-1:0]  data_in, data_ff;
   logic [m3inv_pkg::USER_W-1:0] user_in, user_ff;

   always_comb begin
      logic [NUM-1:0] sat;
      logic [DW-1:0]  q;
      for (int e = 0; e < NUM; e++) begin
         q = div_ff[DW+1].quo[e];
         if (div_ff[DW+1].neg[e]) begin
            sat[e] = div_ff[DW+1].ovf[e] || (q > HALF);
            data_in[e*DW +: DW] = sat[e] ? HALF : -q;
         end else begin
            sat[e] = div_ff[DW+1].ovf[e] || q[DW-1];
            data_in[e*DW +: DW] = sat[e] ? ~HALF : q;
         end
      end
      data_in[NUM*DW +: DW] = div_ff[DW+1].det_out;
      user_in = '0;
      user_in[m3inv_pkg::USER_CLAMPED]   = div_ff[DW+1].clamped;
      user_in[m3inv_pkg::USER_SATURATED] = (|sat) || div_ff[DW+1].det_sat;
   end

   always_ff @(posedge clock) begin
      if (en[NST-1]) begin
         data_ff <= data_in;
         user_ff <= user_in;
      end
   end

   assign rsp_tdata = data_ff;
   assign rsp_tuser = user_ff;

endmodule

// ===== rtl/m3inv_checker.sv =====
// Port-level checker for the 3x3 matrix inverse, bound to the top level.
// Depends on m3inv_pkg for port widths and the pipeline depth.
module m3inv_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [m3inv_pkg::OUT_W-1:0]   rsp_tdata,
   input logic [m3inv_pkg::USER_W-1:0]  rsp_tuser
);

   // Count of matrices taken in whose result has not left yet.
   logic [m3inv_pkg::CNT_W-1:0] inflight_ff, inflight_in;

   always_comb begin
      inflight_in = inflight_ff;
      if (req_tvalid && req_tready) inflight_in = inflight_in + m3inv_pkg::CNT_W'(1);
      if (rsp_tvalid && rsp_tready) inflight_in = inflight_in - m3inv_pkg::CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // Nothing is offered right after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // A stalled result transfer holds its contents.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Every result belongs to a matrix that went in.
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> inflight_ff != '0)
      else $error("result without a pending matrix");

   // The input stalls only when the output is backed up.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output back-pressure");

   // Never more matrices in flight than there are stages.
   a_depth: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= m3inv_pkg::CNT_W'(m3inv_pkg::NST))
      else $error("more matrices in flight than pipeline stages");

endmodule

bind matrix3x3_inverse m3inv_checker u_m3inv_checker (.*);

// ===== bench/tb_matrix3x3_inverse.sv =====
// Self-checking bench for the pipelined 3x3 matrix inverse with a min_det register.
// A directed table goes first, then random matrices under several min_det settings.
// Depends on m3inv_pkg and matrix3x3_inverse only.
`timescale 1ns / 100ps

module tb_matrix3x3_inverse;

   localparam int DATA_W         = m3inv_pkg::DATA_W;
   localparam int SHIFT          = m3inv_pkg::SHIFT;
   localparam int NUM            = m3inv_pkg::NUM;
   localparam int MIN_W          = m3inv_pkg::MIN_W;
   localparam int IN_W           = m3inv_pkg::IN_W;
   localparam int OUT_W          = m3inv_pkg::OUT_W;
   localparam int USER_W         = m3inv_pkg::USER_W;
   localparam int NST            = m3inv_pkg::NST;
   localparam int USER_CLAMPED   = m3inv_pkg::USER_CLAMPED;
   localparam int USER_SATURATED = m3inv_pkg::USER_SATURATED;

   typedef logic signed [159:0] exact_type;

   typedef struct {
      logic [OUT_W-1:0]  data;
      logic [USER_W-1:0] user;
   } inverse_type;

   typedef struct {
      logic [DATA_W-1:0] a [NUM];
      bit                typed;
      logic [DATA_W-1:0] r [NUM+1];
      logic [USER_W-1:0] u;
   } table_row_type;

   localparam int   ROWS        = 14;
   localparam int   DRAIN_WAIT  = NST + 8;
   localparam int   STALL_LIMIT = 3000;
   localparam logic [DATA_W-1:0] ONE = 32'h0001_0000;
   localparam logic [DATA_W-1:0] MAXV = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] MINV = 32'h8000_0000;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [IN_W-1:0]     req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [OUT_W-1:0]    rsp_tdata;
   logic [USER_W-1:0]   rsp_tuser;
   logic                csr_we;
   logic [MIN_W-1:0]    csr_wdata;

   inverse_type         pending_inverses [$];
   logic [MIN_W-1:0]    min_det_copy;
   logic                hold_request;
   bit                  gaps_on;
   int                  fail_count;
   int                  idle_cycles;
   int                  accept_count;
   table_row_type       directed [ROWS];

   matrix3x3_inverse u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Signed division rounded to nearest, ties away from zero.
   function automatic exact_type round_div(input exact_type num, input exact_type den);
      exact_type an, ad, q;
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      q  = (2 * an + ad) / (2 * ad);
      return ((num < 0) != (den < 0)) ? -q : q;
   endfunction

   // Saturate to the signed 32-bit range and note when that happens.
   function automatic logic [DATA_W-1:0] clip(input exact_type v, inout bit sat);
      if (v > exact_type'(64'sh7fff_ffff)) begin
         sat = 1'b1;
         return MAXV;
      end
      if (v < -exact_type'(64'sh8000_0000)) begin
         sat = 1'b1;
         return MINV;
      end
      return v[DATA_W-1:0];
   endfunction

   // Exact adjugate over the (possibly clamped) determinant.
   function automatic inverse_type invert(input logic [IN_W-1:0] mat,
                                          input logic [MIN_W-1:0] md);
      exact_type   m [3][3];
      exact_type   cof [3][3];
      exact_type   det, absdet, lim, used;
      bit          sat, clamped;
      inverse_type res;
      sat = 1'b0;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            m[i][j] = $signed(mat[(i*3+j)*DATA_W +: DATA_W]);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            cof[i][j] = m[(i+1)%3][(j+1)%3] * m[(i+2)%3][(j+2)%3]
                      - m[(i+1)%3][(j+2)%3] * m[(i+2)%3][(j+1)%3];
      det = 0;
      for (int j = 0; j < 3; j++) det = det + m[0][j] * cof[0][j];
      lim = 0;
      lim[MIN_W-1:0] = (md == 0) ? MIN_W'(1) : md;
      lim = lim <<< SHIFT;
      absdet  = (det < 0) ? -det : det;
      clamped = (absdet < lim);
      used    = clamped ? ((det < 0) ? -lim : lim) : det;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            res.data[(i*3+j)*DATA_W +: DATA_W] = clip(round_div(cof[j][i] <<< SHIFT, used), sat);
      res.data[NUM*DATA_W +: DATA_W] = clip(round_div(det, exact_type'(1) <<< SHIFT), sat);
      res.user[USER_CLAMPED]   = clamped;
      res.user[USER_SATURATED] = sat;
      return res;
   endfunction

   // Record the expected inverse of every accepted matrix; a directed row with
   // a typed-in result uses that result instead of the prediction.
   always @(posedge clock) begin
      inverse_type want;
      if (!reset && req_tvalid && req_tready) begin
         want = invert(req_tdata, min_det_copy);
         if (accept_count < ROWS && directed[accept_count].typed) begin
            for (int k = 0; k <= NUM; k++)
               want.data[k*DATA_W +: DATA_W] = directed[accept_count].r[k];
            want.user = directed[accept_count].u;
         end
         pending_inverses.push_back(want);
         accept_count++;
      end
   end

   // Compare each result transfer with the oldest expectation, field by field.
   always @(posedge clock) begin
      inverse_type want;
      string       fname;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_inverses.size() == 0) begin
            $error("result transfer with no matrix outstanding");
            fail_count++;
         end else begin
            want = pending_inverses.pop_front();
            for (int k = 0; k <= NUM; k++) begin
               fname = (k == NUM) ? "determinant" : $sformatf("inv_%0d%0d", k / 3, k % 3);
               if (rsp_tdata[k*DATA_W +: DATA_W] !== want.data[k*DATA_W +: DATA_W]) begin
                  $error("%s expected %h actual %h", fname,
                         want.data[k*DATA_W +: DATA_W], rsp_tdata[k*DATA_W +: DATA_W]);
                  fail_count++;
               end
            end
            if (rsp_tuser[USER_CLAMPED] !== want.user[USER_CLAMPED]) begin
               $error("det_clamped expected %b actual %b",
                      want.user[USER_CLAMPED], rsp_tuser[USER_CLAMPED]);
               fail_count++;
            end
            if (rsp_tuser[USER_SATURATED] !== want.user[USER_SATURATED]) begin
               $error("saturated expected %b actual %b",
                      want.user[USER_SATURATED], rsp_tuser[USER_SATURATED]);
               fail_count++;
            end
         end
      end
   end

   // Receiver: random back-pressure, plus a long hold-off when asked for one.
   initial begin
      int hold;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            hold = 200;
            while (hold > 0) begin
               @(posedge clock);
               hold--;
            end
            hold_request <= 1'b0;
         end else if (!gaps_on) begin
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 99) < 3) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(10, 40)) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(0, 99) < 70);
         end
      end
   end

   // Watchdog: too long without any transfer ends the run.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [IN_W-1:0] pack_matrix(input logic [DATA_W-1:0] a [NUM]);
      logic [IN_W-1:0] v;
      for (int k = 0; k < NUM; k++) v[k*DATA_W +: DATA_W] = a[k];
      return v;
   endfunction

   // Random Q16.16 entry in roughly +/- span.
   function automatic logic [DATA_W-1:0] entry_near(input int unsigned span);
      return DATA_W'($urandom_range(0, 2 * span)) - DATA_W'(span);
   endfunction

   function automatic logic [DATA_W-1:0] extreme_entry();
      case ($urandom_range(0, 6))
         0: return MAXV;
         1: return MINV;
         2: return '0;
         3: return 32'hffff_ffff;
         4: return ONE;
         5: return 32'h0000_0001;
         default: return $urandom;
      endcase
   endfunction

   // Mix of matrix kinds so clamps, saturations and ordinary inverses all appear.
   function automatic logic [IN_W-1:0] random_matrix();
      logic [DATA_W-1:0] a [NUM];
      int kind;
      kind = $urandom_range(0, 9);
      for (int k = 0; k < NUM; k++) begin
         case (kind)
            0, 1:    a[k] = $urandom;
            2, 3, 4: a[k] = entry_near(32'h0004_0000);
            5:       a[k] = entry_near(32'h0000_0400);
            6:       a[k] = extreme_entry();
            7:       a[k] = entry_near(32'h0100_0000);
            default: a[k] = entry_near(32'h0003_0000);
         endcase
      end
      // Some matrices are made singular by repeating a row.
      if (kind >= 8) begin
         a[6] = a[0];
         a[7] = a[1];
         a[8] = a[2];
      end
      return pack_matrix(a);
   endfunction

   // Offer one matrix, after a random gap when gaps are on, and wait for its transfer.
   task automatic send_matrix(input logic [IN_W-1:0] mat);
      int gap;
      gap = 0;
      if (gaps_on) begin
         gap = ($urandom_range(0, 99) < 5) ? $urandom_range(15, 40) : $urandom_range(0, 3);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= mat;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Let the pipe empty, then write min_det.
   task automatic set_min_det(input logic [MIN_W-1:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_inverses.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_we       <= 1'b1;
      csr_wdata    <= value;
      min_det_copy <= value;
      @(posedge clock);
      csr_we       <= 1'b0;
   endtask

   task automatic put_row(input int idx, input logic [DATA_W-1:0] a [NUM]);
      directed[idx].a     = a;
      directed[idx].typed = 1'b0;
   endtask

   // Directed rows; a few carry the expected inverse typed in.
   task automatic build_table();
      logic [DATA_W-1:0] z [NUM+1];
      z = '{default: '0};
      put_row(0, '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
      directed[0].typed = 1'b1;
      directed[0].r = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, ONE};
      directed[0].u = 2'b00;
      put_row(1, '{default: '0});
      directed[1].typed = 1'b1;
      directed[1].r = z;
      directed[1].u = 2'b01;
      put_row(2,  '{default: MAXV});
      put_row(3,  '{default: MINV});
      put_row(4,  '{MINV, 0, 0, 0, MINV, 0, 0, 0, MINV});
      put_row(5,  '{MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV});
      put_row(6,  '{32'h2_0000, 0, 0, 0, 32'h2_0000, 0, 0, 0, 32'h2_0000});
      put_row(7,  '{0, 0, ONE, 0, ONE, 0, ONE, 0, 0});
      put_row(8,  '{ONE, 32'h2_0000, 32'h3_0000, 32'h4_0000, 32'h5_0000, 32'h6_0000,
                    ONE, 32'h2_0000, 32'h3_0000});
      put_row(9,  '{32'h1, 0, 0, 0, 32'h1, 0, 0, 0, 32'h1});
      put_row(10, '{32'hffff_ffff, 0, 0, 0, ONE, 0, 0, 0, ONE});
      put_row(11, '{MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, 32'h0});
      put_row(12, '{32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f,
                    32'hf0f0_f0f0, 32'h3333_3333, 32'hcccc_cccc, 32'h0000_ffff, 32'hffff_0000});
      put_row(13, '{32'h8000, 0, 0, 0, 32'h8000, 0, 0, 0, 32'h8000});
   endtask

   // Main sequence.
   initial begin
      logic [MIN_W-1:0] settings [6];
      int               waited;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_we       = 1'b0;
      csr_wdata    = '0;
      hold_request = 1'b0;
      gaps_on      = 1'b0;
      fail_count   = 0;
      idle_cycles  = 0;
      accept_count = 0;
      min_det_copy = 31'd1;
      build_table();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset value of min_det, no idling.
      for (int r = 0; r < ROWS; r++) begin
         send_matrix(pack_matrix(directed[r].a));
      end

      // Random phases over several min_det settings, extremes among them.
      settings = '{31'd0, 31'h7fff_ffff, 31'h0001_0000, 31'd1, 31'h0000_0100, 31'd0};
      settings[5] = MIN_W'($urandom_range(1, 32'h7fff_ffff));
      for (int p = 0; p < 6; p++) begin
         set_min_det(settings[p]);
         gaps_on = (p != 3);
         if (p == 2) begin
            // Long receiver hold-off while matrices keep coming back to back.
            gaps_on      = 1'b0;
            hold_request <= 1'b1;
         end
         for (int n = 0; n < 65; n++) send_matrix(random_matrix());
      end
      req_tvalid <= 1'b0;
      @(posedge clock);

      // Drain, then allow for the pipeline latency.
      waited = 0;
      while (pending_inverses.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      if (pending_inverses.size() != 0) begin
         $display("simulation failed");
         $finish;
      end else begin
         repeat (DRAIN_WAIT) @(posedge clock);
         if (pending_inverses.size() != 0) begin
            $error("%0d inverses never arrived", pending_inverses.size());
            fail_count++;
         end
         if (fail_count == 0)
            $display("simulation ok");
         else
            $display("simulation failed");
         $finish;
      end
   end

endmodule
